// ===== rtl/als_pkg.sv =====
`timescale 1ns / 1ps

package als_pkg;

	localparam int BPP_DEFAULT = 24;
	localparam int COLOR_BITS  = 24;
	localparam int DUR_W       = 16;
	localparam int SHORT_W     = 10;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 16;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [SHORT_W-1:0] ZERO_HIGH_RST = 10'd20;
	localparam logic [SHORT_W-1:0] ZERO_LOW_RST  = 10'd43;
	localparam logic [SHORT_W-1:0] ONE_HIGH_RST  = 10'd40;
	localparam logic [SHORT_W-1:0] ONE_LOW_RST   = 10'd22;
	localparam logic [DUR_W-1:0]   LATCH_LOW_RST = 16'd4000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ZERO_HIGH = 3'd0,
		REG_ZERO_LOW  = 3'd1,
		REG_ONE_HIGH  = 3'd2,
		REG_ONE_LOW   = 3'd3,
		REG_LATCH_LOW = 3'd4
	} reg_idx_t;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_HIGH  = 2'd1,
		PH_LOW   = 2'd2,
		PH_LATCH = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		CMD_NONE  = 2'd0,
		CMD_PIXEL = 2'd1,
		CMD_LATCH = 2'd2
	} cmd_t;

	typedef struct packed {
		logic [SHORT_W-1:0] zero_high;
		logic [SHORT_W-1:0] zero_low;
		logic [SHORT_W-1:0] one_high;
		logic [SHORT_W-1:0] one_low;
		logic [DUR_W-1:0]   latch_low;
	} cfg_t;

	typedef struct packed {
		cmd_t                  cmd;
		logic                  eof;
		logic [COLOR_BITS-1:0] grb;
	} item_t;

	// a programmed zero behaves as a programmed one
	function automatic logic [DUR_W-1:0] at_least_one(input logic [DUR_W-1:0] v);
		at_least_one = (v == '0) ? DUR_W'(1) : v;
	endfunction

endpackage

// ===== rtl/als_front.sv =====
`timescale 1ns / 1ps

module als_front import als_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        pixel_valid,
	output logic        pixel_stall,
	input  logic        load,
	input  logic [7:0]  green,
	input  logic [7:0]  red,
	input  logic [7:0]  blue,
	input  logic        end_of_frame,
	output item_t       head,
	output logic        head_valid,
	input  logic        pop
);

	item_t       entry_q [QUEUE_DEPTH];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;
	item_t       item_in;
	logic        push;

	always_comb begin
		item_in.grb = {green, red, blue};
		item_in.eof = end_of_frame;
		if (load) begin
			item_in.cmd = CMD_PIXEL;
		end else if (end_of_frame) begin
			item_in.cmd = CMD_LATCH;
		end else begin
			item_in.cmd = CMD_NONE;
		end
	end

	assign pixel_stall = (count_q == 2'(QUEUE_DEPTH));
	assign push        = pixel_valid && !pixel_stall;
	assign head_valid  = (count_q != 2'd0);
	assign head        = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/als_back.sv =====
`timescale 1ns / 1ps

module als_back import als_pkg::*; #(
	parameter int BITS_PER_PIXEL = BPP_DEFAULT
) (
	input  logic  clk,
	input  logic  arst_n,
	input  item_t head,
	input  logic  head_valid,
	output logic  pop,
	input  cfg_t  cfg,
	output logic  result_valid,
	input  logic  result_stall,
	output logic  line_level,
	output logic  ready_res,
	output logic  dropped,
	output logic  latching
);

	localparam int CNT_W = $clog2(BITS_PER_PIXEL);
	localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(BITS_PER_PIXEL - 1);

	phase_t                    phase_q, phase_a, phase_d;
	logic [DUR_W-1:0]          dur_q, dur_a, dur_d, dur_dec;
	logic [BITS_PER_PIXEL-1:0] shift_q, shift_a, shift_d, shift_nxt;
	logic [CNT_W-1:0]          bits_q, bits_a, bits_d;
	logic                      pend_q, pend_a, pend_d;
	logic                      busy;
	logic                      step_en;
	logic                      line_c, latching_c, dropped_c;
	logic                      result_valid_q;
	logic                      line_level_q, ready_q, dropped_q, latching_q;

	assign busy    = (phase_q != PH_IDLE);
	assign step_en = head_valid && (!result_valid_q || !result_stall);
	assign pop     = step_en;

	// start of tick: an idle engine picks up a pixel or a bare latch
	always_comb begin
		phase_a = phase_q;
		dur_a   = dur_q;
		shift_a = shift_q;
		bits_a  = bits_q;
		pend_a  = pend_q;
		if (!busy) begin
			case (head.cmd)
				CMD_PIXEL: begin
					shift_a = BITS_PER_PIXEL'(head.grb) << (BITS_PER_PIXEL - COLOR_BITS);
					bits_a  = LAST_BIT;
					pend_a  = head.eof;
					phase_a = PH_HIGH;
					dur_a   = at_least_one(shift_a[BITS_PER_PIXEL-1] ?
						DUR_W'(cfg.one_high) : DUR_W'(cfg.zero_high));
				end
				CMD_LATCH: begin
					pend_a  = 1'b0;
					phase_a = PH_LATCH;
					dur_a   = at_least_one(cfg.latch_low);
				end
				default: ;
			endcase
		end
	end

	// next state after this tick's count
	always_comb begin
		phase_d   = phase_a;
		shift_d   = shift_a;
		bits_d    = bits_a;
		pend_d    = pend_a;
		dur_dec   = dur_a - DUR_W'(dur_a != '0);
		dur_d     = dur_dec;
		shift_nxt = shift_a << 1;
		if (phase_a != PH_IDLE && dur_dec == '0) begin
			unique case (phase_a)
				PH_HIGH: begin
					phase_d = PH_LOW;
					dur_d   = at_least_one(shift_a[BITS_PER_PIXEL-1] ?
						DUR_W'(cfg.one_low) : DUR_W'(cfg.zero_low));
				end
				PH_LOW: begin
					if (bits_a != '0) begin
						bits_d  = bits_a - CNT_W'(1);
						shift_d = shift_nxt;
						phase_d = PH_HIGH;
						dur_d   = at_least_one(shift_nxt[BITS_PER_PIXEL-1] ?
							DUR_W'(cfg.one_high) : DUR_W'(cfg.zero_high));
					end else if (pend_a) begin
						pend_d  = 1'b0;
						phase_d = PH_LATCH;
						dur_d   = at_least_one(cfg.latch_low);
					end else begin
						phase_d = PH_IDLE;
					end
				end
				PH_LATCH: phase_d = PH_IDLE;
				default:  phase_d = PH_IDLE;
			endcase
		end
	end

	always_comb begin
		line_c     = (phase_a == PH_HIGH);
		latching_c = (phase_a == PH_LATCH);
		dropped_c  = busy && (head.cmd == CMD_PIXEL);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			dur_q   <= '0;
			shift_q <= '0;
			bits_q  <= '0;
			pend_q  <= 1'b0;
		end else if (step_en) begin
			phase_q <= phase_d;
			dur_q   <= dur_d;
			shift_q <= shift_d;
			bits_q  <= bits_d;
			pend_q  <= pend_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (step_en) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en) begin
			line_level_q <= line_c;
			ready_q      <= !busy;
			dropped_q    <= dropped_c;
			latching_q   <= latching_c;
		end
	end

	assign result_valid = result_valid_q;
	assign line_level   = line_level_q;
	assign ready_res    = ready_q;
	assign dropped      = dropped_q;
	assign latching     = latching_q;

	a_idle_count_clear: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_IDLE |-> dur_q == '0)
		else $error("idle engine holds a nonzero duration");

	a_pixel_starts: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && !busy && head.cmd == CMD_PIXEL |=> phase_q != PH_IDLE)
		else $error("accepted pixel did not start a transfer");

	a_drop_only_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && dropped_q |-> !ready_q)
		else $error("drop flagged on an idle tick");

	a_line_low_latch: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && latching_q |-> !line_level_q)
		else $error("line high during latch period");

endmodule

// ===== rtl/addressable_led_serializer.sv =====
`timescale 1ns / 1ps

// Addressable RGB LED serializer, one input transfer per timer tick.
// Input channel (pixel_valid/pixel_stall): load offers a pixel (green, red,
// blue), end_of_frame requests a latch after it, or at once when idle.
// Output channel (result_valid/result_stall): one result per input transfer
// with the wire level for that tick, ready_res, dropped and latching.
// A pixel is sent as BITS_PER_PIXEL pulses, green MSB first; spare low bits
// go out as zeros. Pulse and latch lengths come from the cfg_we/cfg_index/
// cfg_data write port and take effect at the next phase start.
// Throughput is one transfer per cycle while the output is not stalled. A
// transfer is written into the two-entry queue, and the item then moves
// through the pulse engine into the output register.
// A stalled output holds its result; the queue then fills and pixel_stall
// rises after at most two more transfers. Nothing is lost while stalled.
// Reset puts the engine idle, empties the queue and loads the default
// pulse timings; no clearing pass is needed.
module addressable_led_serializer import als_pkg::*; #(
	parameter int BITS_PER_PIXEL = BPP_DEFAULT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  pixel_valid,
	output logic                  pixel_stall,
	input  logic                  load,
	input  logic [7:0]            green,
	input  logic [7:0]            red,
	input  logic [7:0]            blue,
	input  logic                  end_of_frame,
	output logic                  result_valid,
	input  logic                  result_stall,
	output logic                  line_level,
	output logic                  ready_res,
	output logic                  dropped,
	output logic                  latching
);

	cfg_t  cfg_q;
	item_t head;
	logic  head_valid;
	logic  pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.zero_high <= ZERO_HIGH_RST;
			cfg_q.zero_low  <= ZERO_LOW_RST;
			cfg_q.one_high  <= ONE_HIGH_RST;
			cfg_q.one_low   <= ONE_LOW_RST;
			cfg_q.latch_low <= LATCH_LOW_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ZERO_HIGH: cfg_q.zero_high <= cfg_data[SHORT_W-1:0];
				REG_ZERO_LOW:  cfg_q.zero_low  <= cfg_data[SHORT_W-1:0];
				REG_ONE_HIGH:  cfg_q.one_high  <= cfg_data[SHORT_W-1:0];
				REG_ONE_LOW:   cfg_q.one_low   <= cfg_data[SHORT_W-1:0];
				REG_LATCH_LOW: cfg_q.latch_low <= cfg_data[DUR_W-1:0];
				default: ;
			endcase
		end
	end

	als_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.pixel_valid  (pixel_valid),
		.pixel_stall  (pixel_stall),
		.load         (load),
		.green        (green),
		.red          (red),
		.blue         (blue),
		.end_of_frame (end_of_frame),
		.head         (head),
		.head_valid   (head_valid),
		.pop          (pop)
	);

	als_back #(
		.BITS_PER_PIXEL (BITS_PER_PIXEL)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.head_valid   (head_valid),
		.pop          (pop),
		.cfg          (cfg_q),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.line_level   (line_level),
		.ready_res    (ready_res),
		.dropped      (dropped),
		.latching     (latching)
	);

endmodule

// ===== tb/sv/addressable_led_serializer_test.sv =====
`timescale 1ns / 1ps

module addressable_led_serializer_test;
	import als_pkg::*;

	localparam int BPP = BPP_DEFAULT;

	typedef struct packed {
		logic line_level;
		logic ready_res;
		logic dropped;
		logic latching;
	} wire_tick_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  pixel_valid;
	logic                  pixel_stall;
	logic                  load;
	logic [7:0]            green;
	logic [7:0]            red;
	logic [7:0]            blue;
	logic                  end_of_frame;
	logic                  result_valid;
	logic                  result_stall;
	logic                  line_level;
	logic                  ready_res;
	logic                  dropped;
	logic                  latching;

	addressable_led_serializer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.pixel_valid  (pixel_valid),
		.pixel_stall  (pixel_stall),
		.load         (load),
		.green        (green),
		.red          (red),
		.blue         (blue),
		.end_of_frame (end_of_frame),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.line_level   (line_level),
		.ready_res    (ready_res),
		.dropped      (dropped),
		.latching     (latching)
	);

	always #5 clk = ~clk;

	// wire timing mirror
	cfg_t            timing;
	logic [BPP-1:0]  shift_bits;
	int unsigned     bits_to_go;
	phase_t          wire_phase;
	int unsigned     ticks_left;
	logic            latch_after;

	wire_tick_t      wire_ticks_due[$];
	int              mismatches;
	int              stall_ticks;
	bit              pace_on;

	function automatic int unsigned min_one(input int unsigned v);
		return (v == 0) ? 1 : v;
	endfunction

	function automatic void start_high();
		wire_phase = PH_HIGH;
		ticks_left = min_one(shift_bits[BPP-1] ? timing.one_high : timing.zero_high);
	endfunction

	function automatic void start_latch();
		wire_phase = PH_LATCH;
		ticks_left = min_one(timing.latch_low);
	endfunction

	// one timer tick of the wire: returns what the block reports for it
	function automatic wire_tick_t advance_wire(input logic ld, input logic [7:0] g,
			input logic [7:0] r, input logic [7:0] b, input logic eof);
		wire_tick_t t;
		t = '0;
		if (wire_phase == PH_IDLE) begin
			t.ready_res = 1'b1;
			if (ld) begin
				shift_bits  = BPP'({g, r, b}) << (BPP - COLOR_BITS);
				bits_to_go  = BPP - 1;
				latch_after = eof;
				start_high();
			end else if (eof) begin
				latch_after = 1'b0;
				start_latch();
			end
		end else if (ld) begin
			t.dropped = 1'b1;
		end
		t.line_level = (wire_phase == PH_HIGH);
		t.latching   = (wire_phase == PH_LATCH);
		if (wire_phase != PH_IDLE) begin
			if (ticks_left > 0)
				ticks_left--;
			if (ticks_left == 0) begin
				case (wire_phase)
					PH_HIGH: begin
						wire_phase = PH_LOW;
						ticks_left = min_one(shift_bits[BPP-1] ? timing.one_low : timing.zero_low);
					end
					PH_LOW: begin
						if (bits_to_go > 0) begin
							bits_to_go--;
							shift_bits = shift_bits << 1;
							start_high();
						end else if (latch_after) begin
							latch_after = 1'b0;
							start_latch();
						end else begin
							wire_phase = PH_IDLE;
						end
					end
					default: wire_phase = PH_IDLE;
				endcase
			end
		end
		return t;
	endfunction

	// called just after a falling edge, returns just after one
	task automatic send_tick(input logic ld, input logic [7:0] g, input logic [7:0] r,
			input logic [7:0] b, input logic eof);
		int gap;
		gap = pace_on ? $urandom_range(0, 3) : 0;
		if (gap > 0) begin
			pixel_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		pixel_valid  <= 1'b1;
		load         <= ld;
		green        <= g;
		red          <= r;
		blue         <= b;
		end_of_frame <= eof;
		@(posedge clk);
		while (pixel_stall)
			@(posedge clk);
		wire_ticks_due.push_back(advance_wire(ld, g, r, b, eof));
		@(negedge clk);
	endtask

	// tick while busy; now and then a load or latch request that must be ignored
	task automatic filler_tick();
		send_tick($urandom_range(0, 7) == 0, 8'($urandom), 8'($urandom), 8'($urandom),
			$urandom_range(0, 7) == 0);
	endtask

	task automatic run_until_idle();
		while (wire_phase != PH_IDLE)
			filler_tick();
	endtask

	task automatic drain();
		pixel_valid <= 1'b0;
		while (wire_ticks_due.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
		case (reg_idx_t'(idx))
			REG_ZERO_HIGH: timing.zero_high = data[SHORT_W-1:0];
			REG_ZERO_LOW:  timing.zero_low  = data[SHORT_W-1:0];
			REG_ONE_HIGH:  timing.one_high  = data[SHORT_W-1:0];
			REG_ONE_LOW:   timing.one_low   = data[SHORT_W-1:0];
			REG_LATCH_LOW: timing.latch_low = data[DUR_W-1:0];
			default: ;
		endcase
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_timing(input logic [CFG_DATA_W-1:0] zh, input logic [CFG_DATA_W-1:0] zl,
			input logic [CFG_DATA_W-1:0] oh, input logic [CFG_DATA_W-1:0] ol,
			input logic [CFG_DATA_W-1:0] ll);
		write_reg(REG_ZERO_HIGH, zh);
		write_reg(REG_ZERO_LOW, zl);
		write_reg(REG_ONE_HIGH, oh);
		write_reg(REG_ONE_LOW, ol);
		write_reg(REG_LATCH_LOW, ll);
	endtask

	function automatic logic [CFG_DATA_W-1:0] rand_pulse();
		if ($urandom_range(0, 7) == 0)
			return '0;
		return CFG_DATA_W'($urandom_range(1, 4));
	endfunction

	task automatic test_default_timing();
		send_tick(1'b0, 8'h00, 8'h00, 8'h00, 1'b0);
		send_tick(1'b1, 8'h80, 8'h01, 8'h7F, 1'b1);
		// first bit (a one) and part of the second at reset timing
		repeat (70) filler_tick();
		drain();
		set_timing(16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
		run_until_idle();
	endtask

	task automatic test_short_pulses();
		drain();
		set_timing(16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
		send_tick(1'b1, 8'hFF, 8'hFF, 8'hFF, 1'b1);
		run_until_idle();
		// latch straight from idle
		send_tick(1'b0, 8'hFF, 8'h00, 8'hFF, 1'b1);
		run_until_idle();
		send_tick(1'b1, 8'hAA, 8'h55, 8'hAA, 1'b0);
		send_tick(1'b1, 8'h11, 8'h22, 8'h33, 1'b1);
		run_until_idle();
	endtask

	task automatic test_zero_and_masked();
		int i;
		drain();
		// zero durations behave as a programmed one
		set_timing(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
		send_tick(1'b1, 8'h5A, 8'hC3, 8'h0F, 1'b1);
		run_until_idle();
		drain();
		// upper data bits of the short registers are dropped
		set_timing(16'hFC02, 16'h0401, 16'hFC01, 16'h8003, 16'h0002);
		// unknown indexes leave the timing alone
		for (i = int'(REG_LATCH_LOW) + 1; i < (1 << CFG_IDX_W); i++)
			write_reg(CFG_IDX_W'(i), 16'hFFFF);
		send_tick(1'b1, 8'h01, 8'h00, 8'h80, 1'b1);
		run_until_idle();
	endtask

	task automatic test_config_mid_pixel();
		drain();
		set_timing(16'd2, 16'd3, 16'd4, 16'd5, 16'd6);
		send_tick(1'b1, 8'hC3, 8'h3C, 8'h96, 1'b1);
		repeat (20) filler_tick();
		// engine is mid-pixel here; new values apply from the next phase
		drain();
		set_timing(16'd1, 16'd2, 16'd1, 16'd2, 16'd3);
		run_until_idle();
	endtask

	task automatic test_random();
		int round;
		int counted;
		int pick;
		for (round = 0; round < 2; round++) begin
			drain();
			pace_on = (round != 1);
			set_timing(rand_pulse(), rand_pulse(), rand_pulse(), rand_pulse(),
				CFG_DATA_W'($urandom_range(0, 12)));
			counted = 0;
			while (counted < 60) begin
				if (wire_phase != PH_IDLE) begin
					filler_tick();
					counted++;
				end else begin
					pick = $urandom_range(0, 9);
					if (pick < 7) begin
						send_tick(1'b1, 8'($urandom), 8'($urandom), 8'($urandom),
							$urandom_range(0, 2) == 0);
						counted++;
					end else if (pick < 8) begin
						send_tick(1'b0, 8'($urandom), 8'($urandom), 8'($urandom), 1'b1);
						counted++;
					end else begin
						send_tick(1'b0, 8'($urandom), 8'($urandom), 8'($urandom), 1'b0);
					end
				end
			end
		end
		pace_on = 1'b1;
		run_until_idle();
	endtask

	// result checker; also draws the stall for the next result transfer
	always @(posedge clk) begin : check_results
		wire_tick_t due;
		if (arst_n && result_valid && !result_stall) begin
			stall_ticks = pace_on ? $urandom_range(0, 3) : 0;
			if (wire_ticks_due.size() == 0) begin
				$error("result transfer with nothing expected");
				mismatches++;
			end else begin
				due = wire_ticks_due.pop_front();
				if (line_level !== due.line_level) begin
					$error("line_level expected %0b got %0b", due.line_level, line_level);
					mismatches++;
				end
				if (ready_res !== due.ready_res) begin
					$error("ready_res expected %0b got %0b", due.ready_res, ready_res);
					mismatches++;
				end
				if (dropped !== due.dropped) begin
					$error("dropped expected %0b got %0b", due.dropped, dropped);
					mismatches++;
				end
				if (latching !== due.latching) begin
					$error("latching expected %0b got %0b", due.latching, latching);
					mismatches++;
				end
			end
		end
	end

	always @(negedge clk) begin
		if (stall_ticks > 0) begin
			result_stall <= 1'b1;
			stall_ticks--;
		end else begin
			result_stall <= 1'b0;
		end
	end

	initial begin
		#200_000;
		$display("simulation failed");
		$finish;
	end

	initial begin
		clk          = 1'b0;
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		pixel_valid  = 1'b0;
		load         = 1'b0;
		green        = '0;
		red          = '0;
		blue         = '0;
		end_of_frame = 1'b0;
		result_stall = 1'b0;
		stall_ticks  = 0;
		mismatches   = 0;
		pace_on      = 1'b1;
		timing       = '{zero_high: ZERO_HIGH_RST, zero_low: ZERO_LOW_RST,
			one_high: ONE_HIGH_RST, one_low: ONE_LOW_RST, latch_low: LATCH_LOW_RST};
		shift_bits   = '0;
		bits_to_go   = 0;
		wire_phase   = PH_IDLE;
		ticks_left   = 0;
		latch_after  = 1'b0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		test_default_timing();
		test_short_pulses();
		test_zero_and_masked();
		test_config_mid_pixel();
		test_random();

		drain();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && wire_ticks_due.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/als_pkg.sv
rtl/als_front.sv
rtl/als_back.sv
rtl/addressable_led_serializer.sv
tb/sv/addressable_led_serializer_test.sv
